>>> hdl/nths_pkg.sv
// Shared types, constants and the CORDIC angle table for the heading steer block.
// No dependencies.
package nths_pkg;

	// Input command codes.
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_POSE  = 2'd2,
		CMD_TICK  = 2'd3
	} cmd_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_MAX_LOAD    = 3'd0;
	localparam logic [2:0] REG_STATION_X   = 3'd1;
	localparam logic [2:0] REG_STATION_Y   = 3'd2;
	localparam logic [2:0] REG_MAP_HEIGHT  = 3'd3;
	localparam logic [2:0] REG_DRIVE_SPEED = 3'd4;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Angles in Q.12 and Q.20.
	localparam logic signed [17:0] ANG_PI     = 18'sd12868;
	localparam logic signed [17:0] ANG_TWO_PI = 18'sd25736;
	localparam logic signed [17:0] ANG_THRESH = 18'sd1229;
	localparam logic signed [23:0] HALF_PI_Q20 = 24'sd1647099;
	localparam logic signed [23:0] PI_Q20      = 24'sd3294199;

	// Point and angle widths.
	localparam int PIX_W = 16;
	localparam int CORDIC_W = 26;

	// CORDIC arctangent table in Q.20.
	function automatic logic signed [23:0] atan_q20(input logic [4:0] idx);
		logic signed [23:0] v;
		unique case (idx)
			5'd0:  v = 24'sd823550;
			5'd1:  v = 24'sd486170;
			5'd2:  v = 24'sd256879;
			5'd3:  v = 24'sd130396;
			5'd4:  v = 24'sd65451;
			5'd5:  v = 24'sd32757;
			5'd6:  v = 24'sd16383;
			5'd7:  v = 24'sd8192;
			5'd8:  v = 24'sd4096;
			5'd9:  v = 24'sd2048;
			5'd10: v = 24'sd1024;
			5'd11: v = 24'sd512;
			5'd12: v = 24'sd256;
			5'd13: v = 24'sd128;
			5'd14: v = 24'sd64;
			5'd15: v = 24'sd32;
			5'd16: v = 24'sd16;
			5'd17: v = 24'sd8;
			5'd18: v = 24'sd4;
			5'd19: v = 24'sd2;
			default: v = 24'sd0;
		endcase
		return v;
	endfunction

	// Request from the sequencer to the CORDIC unit.
	typedef struct packed {
		logic                    start;
		logic signed [16:0]      dx;
		logic signed [16:0]      dy;
	} cordic_req_t;

	// Answer from the CORDIC unit.
	typedef struct packed {
		logic                    done;
		logic signed [17:0]      angle;
	} cordic_rsp_t;

endpackage

>>> hdl/nths_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module nths_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/nths_cordic.sv
// Iterative vectoring CORDIC: bearing of (dx, dy) in Q.12, one step per cycle.
// Depends on nths_pkg.
module nths_cordic #(
	parameter int CORDIC_STEPS = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  nths_pkg::cordic_req_t req,
	output nths_pkg::cordic_rsp_t rsp
);

	localparam int USED = (CORDIC_STEPS > 20) ? 20 : CORDIC_STEPS;
	localparam int W = nths_pkg::CORDIC_W + 6;

	logic signed [W-1:0] x_q, y_q;
	logic signed [24:0]  z_q;
	logic [4:0]          step_q;
	logic                busy_q, done_q, zero_q;
	logic signed [17:0]  angle_q;

	logic signed [W-1:0] x0, y0, xs, ys;
	logic signed [24:0]  z0, zc, zr;

	// Quadrant pre-rotation of the scaled vector.
	always_comb begin
		x0 = W'(req.dx) <<< 12;
		y0 = W'(req.dy) <<< 12;
		z0 = '0;
		if (req.dx < 0) begin
			if (req.dy >= 0) begin
				x0 = W'(req.dy) <<< 12;
				y0 = -(W'(req.dx) <<< 12);
				z0 = 25'(nths_pkg::HALF_PI_Q20);
			end else begin
				x0 = -(W'(req.dy) <<< 12);
				y0 = W'(req.dx) <<< 12;
				z0 = -25'(nths_pkg::HALF_PI_Q20);
			end
		end
	end

	// Arithmetic shifts floor like the model.
	assign xs = x_q >>> step_q;
	assign ys = y_q >>> step_q;

	// Clamp and round the final angle.
	always_comb begin
		zc = z_q;
		if (z_q > 25'(nths_pkg::PI_Q20)) zc = 25'(nths_pkg::PI_Q20);
		if (z_q < -25'(nths_pkg::PI_Q20)) zc = -25'(nths_pkg::PI_Q20);
		zr = (zc + 25'sd128) >>> 8;
	end

	// Step counter and rotation registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				x_q    <= x0;
				y_q    <= y0;
				z_q    <= z0;
				zero_q <= (req.dx == 0) && (req.dy == 0);
				step_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (32'(step_q) == USED) begin
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
					angle_q <= zero_q ? '0 : 18'(zr);
				end else begin
					if (y_q > 0) begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + 25'(nths_pkg::atan_q20(step_q));
					end else begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - 25'(nths_pkg::atan_q20(step_q));
					end
					step_q <= step_q + 5'd1;
				end
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.angle = angle_q;

endmodule

>>> hdl/nearest_target_heading_steer.sv
// Top level of the heading steer block: target memories, scan sequencer and output stage.
// Depends on nths_pkg, nths_ram and nths_cordic.
//
// One item at a time. Clear, add and pose commands are accepted back to back,
// one a cycle. So is a tick that gives no result because no pose is known or
// the table is empty. A tick that reads the table holds in_ready low while it
// scans the table. The target memories are read one entry a cycle, and the scan
// then waits for the registered read data of the last entry. A tick that heads
// to the station skips the scan. If the chosen target or station lies at
// negative x, the tick ends there with no result. Otherwise it goes on to
// steer and holds in_ready low until its result enters the output register.
// The CORDIC unit uses at most 20 steps, even for a larger CORDIC_STEPS. The
// memory read port sets the scan length, and the shared CORDIC step sets the
// bearing time. A result sits in an output register, and the next item is
// taken while it waits. A second result waits in the steer stage until the
// first has left.
module nearest_target_heading_steer #(
	parameter int MAX_TARGETS  = 64,
	parameter int CORDIC_STEPS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [nths_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [nths_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          command,
	input  logic signed [16:0]                  marker_x,
	input  logic signed [16:0]                  marker_y,
	input  logic                                marker_delete_all,
	input  logic                                marker_in_waste_group,
	input  logic signed [15:0]                  pose_x,
	input  logic signed [15:0]                  pose_y,
	input  logic signed [15:0]                  pose_heading,
	input  logic [15:0]                         pose_load,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [15:0]                         linear_speed,
	output logic signed [16:0]                  angular_rate
);

	localparam int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
	localparam int CW = $clog2(MAX_TARGETS + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_PICK, ST_CORDIC, ST_STEER, ST_OUT
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [15:0]        max_load_q, drive_speed_q;
	logic signed [15:0] station_x_q, station_y_q;
	logic [14:0]        map_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_load_q    <= 16'd100;
			station_x_q   <= '0;
			station_y_q   <= '0;
			map_height_q  <= 15'd16384;
			drive_speed_q <= 16'd4096;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nths_pkg::REG_MAX_LOAD:    max_load_q    <= cfg_data;
				nths_pkg::REG_STATION_X:   station_x_q   <= cfg_data;
				nths_pkg::REG_STATION_Y:   station_y_q   <= cfg_data;
				nths_pkg::REG_MAP_HEIGHT:  map_height_q  <= cfg_data[14:0];
				nths_pkg::REG_DRIVE_SPEED: drive_speed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Marker conversion: m*5/16 rounded, y offset by the map height, then saturated.
	logic signed [20:0] mx5, my5;
	logic signed [20:0] ypix;
	logic [15:0]        conv_x, conv_y;

	function automatic logic [15:0] sat16(input logic signed [20:0] v);
		if (v > 21'sd32767) return 16'h7FFF;
		if (v < -21'sd32768) return 16'h8000;
		return v[15:0];
	endfunction

	always_comb begin
		mx5    = ((21'(marker_x) * 21'sd5) + 21'sd8) >>> 4;
		my5    = ((21'(marker_y) * 21'sd5) + 21'sd8) >>> 4;
		ypix   = my5 + 21'($unsigned(map_height_q));
		conv_x = sat16(mx5);
		conv_y = sat16(ypix);
	end

	// Pose and table state.
	logic signed [15:0] rob_x_q, rob_y_q, rob_head_q;
	logic [15:0]        rob_load_q;
	logic               pose_seen_q;
	logic [CW-1:0]      count_q;

	logic               accept;
	logic               add_ok;
	logic [AW-1:0]      raddr;
	logic [15:0]        rd_x, rd_y;

	assign accept = in_valid && in_ready;
	assign add_ok = accept && (command == nths_pkg::CMD_ADD) && !marker_delete_all
		&& marker_in_waste_group && (count_q < CW'(MAX_TARGETS));

	nths_ram #(.WIDTH(16), .DEPTH(MAX_TARGETS)) u_ram_x (
		.clk(clk), .we(add_ok), .waddr(count_q[AW-1:0]), .wdata(conv_x),
		.raddr(raddr), .rdata(rd_x)
	);
	nths_ram #(.WIDTH(16), .DEPTH(MAX_TARGETS)) u_ram_y (
		.clk(clk), .we(add_ok), .waddr(count_q[AW-1:0]), .wdata(conv_y),
		.raddr(raddr), .rdata(rd_y)
	);

	// Scan bookkeeping.
	logic [CW-1:0]      idx_q;
	logic               rd_vld_s1;
	logic               first_q;
	logic [33:0]        best_q;
	logic signed [15:0] tx_q, ty_q;
	logic signed [16:0] ex, ey;
	logic signed [33:0] sq_dist;

	assign raddr   = idx_q[AW-1:0];
	assign ex      = 17'(rob_x_q) - 17'($signed(rd_x));
	assign ey      = 17'(rob_y_q) - 17'($signed(rd_y));
	assign sq_dist = (34'(ex) * 34'(ex)) + (34'(ey) * 34'(ey));

	// CORDIC unit.
	nths_pkg::cordic_req_t creq;
	nths_pkg::cordic_rsp_t crsp;
	logic                  cstart_q;

	assign creq.start = cstart_q;
	assign creq.dx    = 17'(tx_q) - 17'(rob_x_q);
	assign creq.dy    = 17'(ty_q) - 17'(rob_y_q);

	nths_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .req(creq), .rsp(crsp)
	);

	// Heading difference, wrapped and steered.
	logic signed [17:0] diff_q;
	logic signed [18:0] d0;
	logic signed [17:0] dw;
	logic signed [17:0] dabs;
	logic signed [24:0] rate50;
	logic [15:0]        lin_n;
	logic signed [16:0] rate_n;
	logic               steer_fire;

	// The raw difference can lie up to two turns out, so wrap twice.
	always_comb begin
		d0 = 19'(crsp.angle) - 19'(rob_head_q);
		if (d0 > 19'(nths_pkg::ANG_PI)) d0 = d0 - 19'(nths_pkg::ANG_TWO_PI);
		else if (d0 < -19'(nths_pkg::ANG_PI)) d0 = d0 + 19'(nths_pkg::ANG_TWO_PI);
		if (d0 > 19'(nths_pkg::ANG_PI)) d0 = d0 - 19'(nths_pkg::ANG_TWO_PI);
		else if (d0 < -19'(nths_pkg::ANG_PI)) d0 = d0 + 19'(nths_pkg::ANG_TWO_PI);
		dw = d0[17:0];
	end

	always_comb begin
		dabs   = (diff_q < 0) ? -diff_q : diff_q;
		rate50 = 25'(diff_q) * 25'sd50;
		if (dabs < nths_pkg::ANG_THRESH) begin
			lin_n = drive_speed_q;
			if (rate50 > 25'sd65535) rate_n = 17'sd65535;
			else if (rate50 < -25'sd65536) rate_n = -17'sd65536;
			else rate_n = rate50[16:0];
		end else begin
			lin_n  = '0;
			rate_n = (diff_q > 0) ? 17'($unsigned(drive_speed_q))
				: -17'($unsigned(drive_speed_q));
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign steer_fire = (state_q == ST_STEER) && (!out_valid || out_ready);

	// Sequencer: commands, scan, bearing and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pose_seen_q <= 1'b0;
			rob_x_q     <= '0;
			rob_y_q     <= '0;
			rob_head_q  <= '0;
			rob_load_q  <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
			first_q     <= 1'b0;
			cstart_q    <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			cstart_q <= 1'b0;
			if (steer_fire) begin
				out_valid <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (nths_pkg::cmd_t'(command))
							nths_pkg::CMD_CLEAR: count_q <= '0;
							nths_pkg::CMD_ADD: begin
								if (add_ok) count_q <= count_q + CW'(1);
							end
							nths_pkg::CMD_POSE: begin
								rob_x_q     <= pose_x;
								rob_y_q     <= pose_y;
								rob_head_q  <= pose_heading;
								rob_load_q  <= pose_load;
								pose_seen_q <= 1'b1;
							end
							nths_pkg::CMD_TICK: begin
								if (pose_seen_q) begin
									if (rob_load_q >= max_load_q) begin
										tx_q    <= station_x_q;
										ty_q    <= station_y_q;
										state_q <= ST_PICK;
									end else if (count_q != '0) begin
										idx_q     <= '0;
										first_q   <= 1'b1;
										rd_vld_s1 <= 1'b0;
										state_q   <= ST_SCAN;
									end
								end
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					// Read data is registered behind the address: compare the entry fetched last cycle.
					if (rd_vld_s1) begin
						if (first_q || ($unsigned(sq_dist) < best_q)) begin
							best_q <= $unsigned(sq_dist);
							tx_q   <= rd_x;
							ty_q   <= rd_y;
						end
						first_q <= 1'b0;
					end
					if (idx_q < count_q) begin
						idx_q     <= idx_q + CW'(1);
						rd_vld_s1 <= 1'b1;
					end else begin
						rd_vld_s1 <= 1'b0;
						if (rd_vld_s1) state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (tx_q < 0) begin
						state_q <= ST_IDLE;
					end else begin
						cstart_q <= 1'b1;
						state_q  <= ST_CORDIC;
					end
				end
				ST_CORDIC: begin
					if (crsp.done) begin
						diff_q  <= dw;
						state_q <= ST_STEER;
					end
				end
				ST_STEER: begin
					if (steer_fire) begin
						linear_speed <= lin_n;
						angular_rate <= rate_n;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/nths_checker.sv
// Port-level checks for the heading steer block, bound to the top level.
// Depends on nths_pkg and nearest_target_heading_steer.
module nths_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  command,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] linear_speed,
	input logic signed [16:0] angular_rate
);

	// A held result keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(linear_speed)
			&& $stable(angular_rate))
		else $error("result changed while stalled");

	// Non-tick commands never make a result next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command != nths_pkg::CMD_TICK && !out_valid |=> !out_valid)
		else $error("result without a tick");

	// While in reset the block is ready and holds no result.
	assert property (@(posedge clk) !arst_n |-> in_ready && !out_valid)
		else $error("not idle during reset");

	// When driving forward, the turn rate stays inside the proportional band.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && linear_speed != 16'd0 |->
			angular_rate <= 17'sd61450 && angular_rate >= -17'sd61450)
		else $error("drive rate outside band");

endmodule

bind nearest_target_heading_steer nths_checker u_nths_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.command(command), .out_valid(out_valid), .out_ready(out_ready),
	.linear_speed(linear_speed), .angular_rate(angular_rate)
);

>>> test/tb_top.sv
// Self-checking testbench for nearest_target_heading_steer: directed table, then random beats.
// Depends on nths_pkg and the block's RTL; a built-in steering predictor checks each result.
`timescale 1ns / 100ps

module tb_top;

	localparam int TABLE_DEPTH = 64;
	localparam int STEPS = 14;
	localparam int LIMIT_CYCLES = 1500000;
	localparam int RANDOM_BEATS = 1900;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [nths_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [nths_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] command = nths_pkg::CMD_CLEAR;
	logic signed [16:0] marker_x = '0;
	logic signed [16:0] marker_y = '0;
	logic marker_delete_all = 1'b0;
	logic marker_in_waste_group = 1'b0;
	logic signed [15:0] pose_x = '0;
	logic signed [15:0] pose_y = '0;
	logic signed [15:0] pose_heading = '0;
	logic [15:0] pose_load = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [15:0] linear_speed;
	logic signed [16:0] angular_rate;

	nearest_target_heading_steer dut (.*);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	typedef struct packed {
		logic [1:0] cmd;
		logic signed [16:0] mx;
		logic signed [16:0] my;
		logic del;
		logic waste;
		logic signed [15:0] px;
		logic signed [15:0] py;
		logic signed [15:0] hd;
		logic [15:0] ld;
	} beat_t;

	typedef struct packed {
		logic [15:0] lin;
		logic signed [16:0] rate;
	} steer_t;

	// Predictor state and configuration copy.
	logic signed [15:0] tgt_x [TABLE_DEPTH];
	logic signed [15:0] tgt_y [TABLE_DEPTH];
	int tgt_count;
	logic signed [15:0] rob_x, rob_y, rob_hd;
	logic [15:0] rob_load;
	bit have_pose;
	logic [15:0] lim_load, speed_set;
	logic signed [15:0] dock_x, dock_y;
	logic [14:0] map_h;

	steer_t steer_queue[$];
	int failures = 0;
	int steer_seen = 0;
	int cycle_count = 0;
	int stall_left = 0;
	bit quiet = 1'b0;
	bit tail_phase = 1'b0;

	// Floor division by a power of two.
	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp16(longint v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic longint arctan_step(int i);
		longint tbl[20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
			8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
		return tbl[i];
	endfunction

	// Vectoring CORDIC bearing, rounded to Q.12.
	function automatic longint bearing(longint dx, longint dy);
		longint x, y, z, t, xs, ys;
		x = dx * 4096;
		y = dy * 4096;
		z = 0;
		if (dx == 0 && dy == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = 1647099;
			end else begin
				t = x; x = -y; y = t; z = -1647099;
			end
		end
		for (int i = 0; i < STEPS; i++) begin
			xs = floor_shift(x, i);
			ys = floor_shift(y, i);
			if (y > 0) begin
				x = x + ys; y = y - xs; z += arctan_step(i);
			end else begin
				x = x - ys; y = y + xs; z -= arctan_step(i);
			end
		end
		if (z > 3294199) z = 3294199;
		if (z < -3294199) z = -3294199;
		return floor_shift(z + 128, 8);
	endfunction

	function automatic void predictor_reset();
		tgt_count = 0;
		rob_x = 0; rob_y = 0; rob_hd = 0; rob_load = 0;
		have_pose = 0;
		lim_load = 100; dock_x = 0; dock_y = 0; map_h = 15'd16384; speed_set = 4096;
	endfunction

	// Applies one beat to the steering predictor; queues a result if one is due.
	function automatic void predict_steer(beat_t b);
		longint tx, ty, ang, diff, rate, ex, ey, d, best;
		steer_t r;
		case (nths_pkg::cmd_t'(b.cmd))
			nths_pkg::CMD_CLEAR: tgt_count = 0;
			nths_pkg::CMD_ADD: begin
				if (!b.del && b.waste && tgt_count < TABLE_DEPTH) begin
					tgt_x[tgt_count] = 16'(clamp16(floor_shift(longint'(b.mx) * 5 + 8, 4)));
					tgt_y[tgt_count] = 16'(clamp16(longint'(map_h) +
						floor_shift(longint'(b.my) * 5 + 8, 4)));
					tgt_count++;
				end
			end
			nths_pkg::CMD_POSE: begin
				rob_x = b.px; rob_y = b.py; rob_hd = b.hd; rob_load = b.ld;
				have_pose = 1;
			end
			nths_pkg::CMD_TICK: begin
				if (!have_pose) return;
				if (rob_load >= lim_load) begin
					tx = dock_x; ty = dock_y;
				end else begin
					if (tgt_count == 0) return;
					best = 0; tx = 0; ty = 0;
					for (int i = 0; i < tgt_count; i++) begin
						ex = longint'(rob_x) - tgt_x[i];
						ey = longint'(rob_y) - tgt_y[i];
						d = ex * ex + ey * ey;
						if (i == 0 || d < best) begin
							best = d; tx = tgt_x[i]; ty = tgt_y[i];
						end
					end
				end
				if (tx < 0) return;
				ang = bearing(tx - rob_x, ty - rob_y);
				diff = ang - rob_hd;
				while (diff > 12868) diff -= 25736;
				while (diff < -12868) diff += 25736;
				if ((diff < 0 ? -diff : diff) < 1229) begin
					r.lin = speed_set;
					rate = diff * 50;
					if (rate > 65535) rate = 65535;
					if (rate < -65536) rate = -65536;
				end else begin
					r.lin = 0;
					rate = diff > 0 ? longint'(speed_set) : -longint'(speed_set);
				end
				r.rate = rate[16:0];
				steer_queue.insert(steer_queue.size(), r);
			end
		endcase
	endfunction

	// Random receiver stalls, none in the tail.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!out_ready) begin
			out_ready <= 1'b1;
		end else if (!tail_phase && $urandom_range(0, 3) == 0) begin
			out_ready <= 1'b0;
			stall_left <= int'($urandom_range(0, 2));
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Result checker.
	always @(posedge clk) begin
		steer_t e;
		if (arst_n && out_valid && out_ready) begin
			steer_seen++;
			if (steer_queue.size() == 0) begin
				$error("unexpected result lin=%0d rate=%0d", linear_speed, angular_rate);
				failures++;
			end else begin
				e = steer_queue.pop_front();
				if (linear_speed !== e.lin) begin
					$error("linear_speed expected %0d actual %0d", e.lin, linear_speed);
					failures++;
				end
				if (angular_rate !== e.rate) begin
					$error("angular_rate expected %0d actual %0d", e.rate, angular_rate);
					failures++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		if (cycle_count > LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Writes one register; the caller drops cfg_we after the last write.
	task automatic write_reg(logic [nths_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			nths_pkg::REG_MAX_LOAD: lim_load = val;
			nths_pkg::REG_STATION_X: dock_x = val;
			nths_pkg::REG_STATION_Y: dock_y = val;
			nths_pkg::REG_MAP_HEIGHT: map_h = val[14:0];
			nths_pkg::REG_DRIVE_SPEED: speed_set = val;
			default: ;
		endcase
	endtask

	// Drives one beat and waits for acceptance; gaps come before it at random.
	task automatic send_beat(beat_t b);
		if (!tail_phase && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= b.cmd;
		marker_x <= b.mx; marker_y <= b.my;
		marker_delete_all <= b.del; marker_in_waste_group <= b.waste;
		pose_x <= b.px; pose_y <= b.py; pose_heading <= b.hd; pose_load <= b.ld;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_steer(b);
	endtask

	// Stops sending and waits until every expected result has arrived.
	task automatic hold_off();
		in_valid <= 1'b0;
		@(posedge clk);
		while (steer_queue.size() != 0) @(posedge clk);
	endtask

	// Waits until all results have arrived, then lets the scan finish.
	task automatic drain();
		hold_off();
		repeat (TABLE_DEPTH + STEPS + 20) @(posedge clk);
	endtask

	function automatic beat_t mk(logic [1:0] c);
		beat_t b;
		b = '0;
		b.cmd = c;
		return b;
	endfunction

	function automatic beat_t rand_beat(logic [1:0] c);
		beat_t b;
		b.cmd = c;
		b.mx = 17'($urandom); b.my = 17'($urandom);
		b.del = ($urandom_range(0, 9) == 0);
		b.waste = ($urandom_range(0, 9) != 0);
		b.px = 16'($urandom); b.py = 16'($urandom);
		b.hd = 16'($urandom);
		b.ld = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 150));
		// Keep many points in the positive, reachable region.
		if ($urandom_range(0, 2) != 0) begin
			b.mx = 17'($urandom_range(0, 65535));
			b.my = 17'($urandom_range(0, 131071)) - 17'sd65536;
			b.px = 16'($urandom_range(0, 32767));
			b.py = 16'($urandom_range(0, 32767));
		end
		return b;
	endfunction

	// Directed table row: beat plus an optional typed-in expectation.
	typedef struct packed {
		beat_t b;
		logic known;
		steer_t want;
	} row_t;

	initial begin
		row_t rows[$];
		row_t r;
		beat_t b;
		int n;
		int c;
		steer_t w;

		predictor_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: tick before pose, empty table, extremes, skips, station.
		r = '0; r.b = mk(nths_pkg::CMD_TICK); rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_POSE); rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_TICK); rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_ADD); r.b.waste = 1'b1;
		r.b.mx = 17'sd65535; r.b.my = 17'sd65535;
		rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_ADD); r.b.waste = 1'b1;
		r.b.mx = 17'h10000; r.b.my = 17'h10000;
		rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_ADD); r.b.waste = 1'b1; r.b.del = 1'b1; r.b.mx = 17'sd100;
		rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_ADD); r.b.waste = 1'b0; r.b.mx = 17'sd100;
		rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_TICK); rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_POSE); r.b.px = 16'sd32767; r.b.py = 16'sd32767;
		r.b.hd = 16'sd32767; r.b.ld = 16'hFFFF;
		rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_TICK); rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_POSE); r.b.px = 16'h8000; r.b.py = 16'h8000;
		r.b.hd = 16'h8000;
		rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_TICK); rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_CLEAR); rows.insert(rows.size(), r);
		// Station equals robot position: zero vector, heading zero, drive straight.
		r.b = mk(nths_pkg::CMD_POSE); r.b.ld = 16'd100; rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_TICK); r.known = 1'b1;
		r.want.lin = 16'd4096; r.want.rate = '0;
		rows.insert(rows.size(), r);
		r.known = 1'b0;
		// Negative target x: no result.
		r.b = mk(nths_pkg::CMD_ADD); r.b.waste = 1'b1; r.b.mx = -17'sd1000;
		rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_POSE); r.b.ld = 16'd0; rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_TICK); rows.insert(rows.size(), r);
		// Tie: two equal points, first wins.
		r.b = mk(nths_pkg::CMD_CLEAR); rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_ADD); r.b.waste = 1'b1; r.b.mx = 17'sd3000;
		r.b.my = -17'sd52429;
		rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_ADD); r.b.waste = 1'b1; r.b.mx = 17'sd3000;
		r.b.my = -17'sd52429;
		rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_POSE); r.b.hd = 16'h8000; rows.insert(rows.size(), r);
		r.b = mk(nths_pkg::CMD_TICK); rows.insert(rows.size(), r);

		foreach (rows[i]) begin
			if (rows[i].known) begin
				send_beat(rows[i].b);
				if (steer_queue.size() == 0 || steer_queue[$] != rows[i].want) begin
					$error("directed row %0d expected lin=%0d rate=%0d", i,
						rows[i].want.lin, rows[i].want.rate);
					failures++;
				end
			end else
				send_beat(rows[i].b);
		end
		drain();

		// Full table: 70 adds, overflow ignored, then a pose and one tick.
		for (int i = 0; i < 70; i++) begin
			b = rand_beat(nths_pkg::CMD_ADD); b.del = 1'b0; b.waste = 1'b1;
			send_beat(b);
		end
		b = rand_beat(nths_pkg::CMD_POSE); b.ld = 16'd0; send_beat(b);
		send_beat(mk(nths_pkg::CMD_TICK));
		drain();

		// Random phases under several register settings, extremes included.
		n = 0;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(nths_pkg::REG_MAX_LOAD, 16'd0);
					write_reg(nths_pkg::REG_DRIVE_SPEED, 16'hFFFF);
					write_reg(nths_pkg::REG_STATION_X, 16'h7FFF);
					write_reg(nths_pkg::REG_STATION_Y, 16'h8000);
					write_reg(nths_pkg::REG_MAP_HEIGHT, 16'h7FFF);
				end
				1: begin
					write_reg(nths_pkg::REG_MAX_LOAD, 16'hFFFF);
					write_reg(nths_pkg::REG_DRIVE_SPEED, 16'd0);
					write_reg(nths_pkg::REG_MAP_HEIGHT, 16'd0);
				end
				2: begin
					write_reg(nths_pkg::REG_STATION_X, 16'h8000);
					write_reg(nths_pkg::REG_STATION_Y, 16'h7FFF);
					write_reg(nths_pkg::REG_MAX_LOAD, 16'd100);
				end
				default: begin
					write_reg(nths_pkg::REG_MAX_LOAD, 16'($urandom_range(0, 150)));
					write_reg(nths_pkg::REG_STATION_X, 16'($urandom_range(0, 32767)));
					write_reg(nths_pkg::REG_STATION_Y, 16'($urandom));
					write_reg(nths_pkg::REG_MAP_HEIGHT, 16'($urandom_range(0, 32767)));
					write_reg(nths_pkg::REG_DRIVE_SPEED, 16'($urandom));
				end
			endcase
			cfg_we <= 1'b0;
			tail_phase = (ph == 5);
			for (int k = 0; k < RANDOM_BEATS / 6; k++) begin
				c = $urandom_range(0, 9);
				if (c < 4) b = rand_beat(nths_pkg::CMD_ADD);
				else if (c < 6) b = rand_beat(nths_pkg::CMD_POSE);
				else if (c < 9) b = rand_beat(nths_pkg::CMD_TICK);
				else b = rand_beat(nths_pkg::CMD_CLEAR);
				send_beat(b);
				n++;
				// Hold off the sender until all results are in.
				if (k == 100) hold_off();
			end
			drain();
		end

		$display("Ran %0d random beats across six register settings;", n);
		$display("%0d steering results checked in all.", steer_seen);
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

>>> filelist.f
hdl/nths_pkg.sv
hdl/nths_ram.sv
hdl/nths_cordic.sv
hdl/nearest_target_heading_steer.sv
hdl/nths_checker.sv
test/tb_top.sv
